FILE: rtl/pts_pkg.sv
// Shared types and constants for the preemptive priority tick scheduler.
`default_nettype none

package pts_pkg;

    localparam int DEF_MAX_SLOTS = 128;

    localparam int SLOT_W  = 7;
    localparam int WORK_W  = 16;
    localparam int TICK_W  = 16;
    localparam int PRIO_W  = 10;
    localparam int TIME_W  = 24;
    localparam int SUM_W   = 31;
    localparam int COUNT_W = 8;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
        logic [WORK_W-1:0] burst_length;
        logic [TICK_W-1:0] arrival;
        logic [PRIO_W-1:0] prio_level;
    } t_in;

    typedef struct packed {
        logic               ran;
        logic [SLOT_W-1:0]  run_slot;
        logic               finished;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting;
        logic [SUM_W-1:0]   total_waiting;
        logic [SUM_W-1:0]   total_turnaround;
        logic               all_done;
        logic [TIME_W-1:0]  now_time;
    } t_out;

    // One process table entry; work == 0 marks an empty slot.
    typedef struct packed {
        logic [WORK_W-1:0] work;
        logic [WORK_W-1:0] burst;
        logic [TICK_W-1:0] arrive;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_WAIT,
        ST_SUMS
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/priority_preemptive_tick_scheduler_unit.sv
// Top level of the preemptive priority tick scheduler: table memory and sequencer.
//
//  channel   signals                              flow control
//  --------  -----------------------------------  ---------------------------
//  command   start, busy, i_in (t_in)             beat when start && !busy
//  result    o_res_stb, o_res (t_out)             one-cycle strobe, no stall
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data beat when valid && ready
//
// A load's result strobes the next cycle and busy stays low.
// A tick scans one table entry per cycle through a single comparator, then
// steps through ST_LAST, ST_UPDATE, ST_WAIT and ST_SUMS for the update and the
// stats; busy stays high throughout and the result strobes as busy drops.
// After reset the table is cleared one entry per cycle; busy is high
// meanwhile. Config writes are taken at any time.
`default_nettype none

module priority_preemptive_tick_scheduler_unit
    import pts_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_in                i_in,
    output logic                    o_res_stb,
    output t_out                    o_res,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [COUNT_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);

    t_state r_state, n_state;

    // table memory
    t_entry        r_mem [MAX_SLOTS];
    t_entry        r_rd;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;

    logic [IW-1:0]      r_idx, n_idx;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [COUNT_W-1:0] r_fin_cnt, n_fin_cnt;
    logic [SUM_W-1:0]   r_sum_wait, n_sum_wait;
    logic [SUM_W-1:0]   r_sum_tat, n_sum_tat;
    logic [COUNT_W-1:0] r_proc_cnt;
    logic               r_fin, n_fin;
    logic [TIME_W-1:0]  r_tat, n_tat;
    logic [TIME_W-1:0]  r_wait, n_wait;
    logic               r_stb, n_stb;
    t_out               r_res, n_res;

    logic          accept;
    logic          pick_found;
    logic [IW-1:0] pick_idx;
    t_entry        pick_ent;
    logic [SUM_W:0] wsum, tsum;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_stb   = r_stb;
    assign o_res       = r_res;

    pts_pick #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (accept),
        .i_vld   (r_rd_vld),
        .i_ent   (r_rd),
        .i_idx   (r_rd_idx),
        .i_now   (r_time),
        .o_found (pick_found),
        .o_idx   (pick_idx),
        .o_ent   (pick_ent)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == LAST_IDX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && i_in.opcode == OP_TICK) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) n_state = ST_LAST;
            end
            ST_LAST:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_WAIT;
            ST_WAIT:   n_state = ST_SUMS;
            ST_SUMS:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign wsum = (SUM_W+1)'(r_sum_wait) + (SUM_W+1)'(r_wait);
    assign tsum = (SUM_W+1)'(r_sum_tat) + (SUM_W+1)'(r_tat);

    // datapath and outputs
    always_comb begin
        n_idx      = r_idx;
        n_time     = r_time;
        n_fin_cnt  = r_fin_cnt;
        n_sum_wait = r_sum_wait;
        n_sum_tat  = r_sum_tat;
        n_fin      = r_fin;
        n_tat      = r_tat;
        n_wait     = r_wait;
        n_stb      = 1'b0;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_wa     = r_idx;
        mem_wd     = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
            end
            ST_IDLE: begin
                n_idx = '0;
                if (accept && i_in.opcode == OP_LOAD) begin
                    // loads past the table are dropped
                    mem_we       = (32'(i_in.slot) < MAX_SLOTS);
                    mem_wa       = IW'(i_in.slot);
                    mem_wd.work  = i_in.burst_length;
                    mem_wd.burst = i_in.burst_length;
                    mem_wd.arrive = i_in.arrival;
                    mem_wd.prio  = i_in.prio_level;
                    n_stb        = 1'b1;
                    n_res        = '0;
                    n_res.total_waiting    = r_sum_wait;
                    n_res.total_turnaround = r_sum_tat;
                    n_res.all_done         = (r_fin_cnt == r_proc_cnt);
                    n_res.now_time         = r_time;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + 1'b1;
            end
            ST_LAST: begin
                n_idx = '0;
            end
            ST_UPDATE: begin
                if (r_time != TIME_MAX) n_time = r_time + 1'b1;
                n_fin = pick_found && (pick_ent.work == WORK_W'(1));
                n_tat = n_time - TIME_W'(pick_ent.arrive);
                if (pick_found) begin
                    mem_we      = 1'b1;
                    mem_wa      = pick_idx;
                    mem_wd      = pick_ent;
                    mem_wd.work = pick_ent.work - 1'b1;
                end
            end
            ST_WAIT: begin
                n_wait = (r_tat >= TIME_W'(pick_ent.burst)) ?
                         r_tat - TIME_W'(pick_ent.burst) : '0;
            end
            ST_SUMS: begin
                if (r_fin) begin
                    n_sum_wait = wsum[SUM_W] ? SUM_MAX : wsum[SUM_W-1:0];
                    n_sum_tat  = tsum[SUM_W] ? SUM_MAX : tsum[SUM_W-1:0];
                    if (r_fin_cnt != COUNT_MAX) n_fin_cnt = r_fin_cnt + 1'b1;
                end
                n_stb                  = 1'b1;
                n_res.ran              = pick_found;
                n_res.run_slot         = pick_found ? SLOT_W'(pick_idx) : '0;
                n_res.finished         = r_fin;
                n_res.turnaround       = r_fin ? r_tat : '0;
                n_res.waiting          = r_fin ? r_wait : '0;
                n_res.total_waiting    = n_sum_wait;
                n_res.total_turnaround = n_sum_tat;
                n_res.all_done         = (n_fin_cnt == r_proc_cnt);
                n_res.now_time         = r_time;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_idx      <= '0;
            r_time     <= '0;
            r_fin_cnt  <= '0;
            r_sum_wait <= '0;
            r_sum_tat  <= '0;
            r_proc_cnt <= '0;
            r_stb      <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_time     <= n_time;
            r_fin_cnt  <= n_fin_cnt;
            r_sum_wait <= n_sum_wait;
            r_sum_tat  <= n_sum_tat;
            r_stb      <= n_stb;
            r_rd_vld   <= (r_state == ST_SCAN);
            if (i_cfg_valid && o_cfg_ready) r_proc_cnt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin    <= n_fin;
        r_tat    <= n_tat;
        r_wait   <= n_wait;
        r_res    <= n_res;
        r_rd_idx <= r_idx;
    end

    // single write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[r_idx];
    end

endmodule

`default_nettype wire

FILE: rtl/pts_pick.sv
// Shared comparator that tracks the best eligible entry during a table scan.
`default_nettype none

module pts_pick
    import pts_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_clr,
    input  wire logic                         i_vld,
    input  wire t_entry                       i_ent,
    input  wire logic [$clog2(MAX_SLOTS)-1:0] i_idx,
    input  wire logic [TIME_W-1:0]            i_now,
    output logic                              o_found,
    output logic [$clog2(MAX_SLOTS)-1:0]      o_idx,
    output t_entry                            o_ent
);

    localparam int IW = $clog2(MAX_SLOTS);

    logic          r_found;
    logic [IW-1:0] r_idx;
    t_entry        r_ent;
    logic          elig;
    logic          take;

    // strict less-than keeps the lowest slot on a priority tie
    assign elig = (i_ent.work != '0) && (TIME_W'(i_ent.arrive) <= i_now);
    assign take = i_vld && elig && (!r_found || (i_ent.prio < r_ent.prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx <= i_idx;
            r_ent <= i_ent;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_ent   = r_ent;

endmodule

`default_nettype wire

FILE: rtl/pts_chk.sv
// Port-level checks for the scheduler top level, bound in below.
`default_nettype none

module pts_chk
    import pts_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire t_in                i_in,
    input wire logic               o_res_stb,
    input wire t_out               o_res,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic [COUNT_W-1:0] i_cfg_data
);

    // a load beat gives its result on the very next cycle
    a_load_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.opcode == OP_LOAD) |=> o_res_stb)
        else $error("load beat without result on next cycle");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.opcode == OP_TICK) |=> (busy && !o_res_stb))
        else $error("tick beat did not hold busy");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_stb && !o_res.ran) |->
        (o_res.run_slot == '0 && !o_res.finished && o_res.turnaround == '0))
        else $error("idle result carries run fields");

    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_stb && o_res.finished) |->
        (o_res.ran && o_res.waiting <= o_res.turnaround))
        else $error("finished result inconsistent");

endmodule

bind priority_preemptive_tick_scheduler_unit pts_chk u_pts_chk (.*);

`default_nettype wire

FILE: bench/priority_preemptive_tick_scheduler_unit_tb.sv
// Self-checking testbench for the preemptive priority tick scheduler: table loads, ticks, totals.

import pts_pkg::*;

class sched_scoreboard;
    logic [WORK_W-1:0]  work_left [DEF_MAX_SLOTS];
    logic [WORK_W-1:0]  burst_len [DEF_MAX_SLOTS];
    logic [TICK_W-1:0]  arrive_at [DEF_MAX_SLOTS];
    logic [PRIO_W-1:0]  prio_of   [DEF_MAX_SLOTS];
    logic [TIME_W-1:0]  now;
    logic [COUNT_W-1:0] done_cnt;
    logic [COUNT_W-1:0] proc_count;
    logic [SUM_W-1:0]   sum_wait;
    logic [SUM_W-1:0]   sum_tat;
    t_out               due_results[$];
    int                 errors;

    function new();
        foreach (work_left[i]) begin
            work_left[i] = '0;
            burst_len[i] = '0;
            arrive_at[i] = '0;
            prio_of[i]   = '0;
        end
        now        = '0;
        done_cnt   = '0;
        proc_count = '0;
        sum_wait   = '0;
        sum_tat    = '0;
        errors     = 0;
    endfunction

    function logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [TIME_W-1:0] add);
        logic [SUM_W:0] s;
        s = (SUM_W+1)'(acc) + (SUM_W+1)'(add);
        return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // Works out the result of one accepted command and queues it.
    function void schedule_item(t_in item);
        t_out              r;
        logic              found;
        int                best;
        logic [TIME_W-1:0] tat;
        r     = '0;
        found = 1'b0;
        best  = 0;
        if (item.opcode == OP_LOAD) begin
            work_left[item.slot] = item.burst_length;
            burst_len[item.slot] = item.burst_length;
            arrive_at[item.slot] = item.arrival;
            prio_of[item.slot]   = item.prio_level;
        end else begin
            for (int i = 0; i < DEF_MAX_SLOTS; i++) begin
                if (work_left[i] != 0 && arrive_at[i] <= now &&
                    (!found || prio_of[i] < prio_of[best])) begin
                    found = 1'b1;
                    best  = i;
                end
            end
            if (now != TIME_MAX) now++;
            if (found) begin
                r.ran      = 1'b1;
                r.run_slot = best[SLOT_W-1:0];
                work_left[best]--;
                if (work_left[best] == 0) begin
                    tat          = now - arrive_at[best];
                    r.finished   = 1'b1;
                    r.turnaround = tat;
                    r.waiting    = (tat >= burst_len[best]) ? tat - burst_len[best] : '0;
                    sum_wait     = sat_sum(sum_wait, r.waiting);
                    sum_tat      = sat_sum(sum_tat, tat);
                    if (done_cnt != COUNT_MAX) done_cnt++;
                end
            end
        end
        r.total_waiting    = sum_wait;
        r.total_turnaround = sum_tat;
        r.all_done         = (done_cnt == proc_count);
        r.now_time         = now;
        due_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(t_out got);
        t_out want;
        if (due_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
            return;
        end
        want = due_results.pop_front();
        compare_field("ran", 32'(got.ran), 32'(want.ran));
        compare_field("run_slot", 32'(got.run_slot), 32'(want.run_slot));
        compare_field("finished", 32'(got.finished), 32'(want.finished));
        compare_field("turnaround", 32'(got.turnaround), 32'(want.turnaround));
        compare_field("waiting", 32'(got.waiting), 32'(want.waiting));
        compare_field("total_waiting", 32'(got.total_waiting), 32'(want.total_waiting));
        compare_field("total_turnaround", 32'(got.total_turnaround),
                      32'(want.total_turnaround));
        compare_field("all_done", 32'(got.all_done), 32'(want.all_done));
        compare_field("now_time", 32'(got.now_time), 32'(want.now_time));
    endtask
endclass

module priority_preemptive_tick_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 260;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    t_in                i_in        = '0;
    logic               o_res_stb;
    t_out               o_res;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data  = '0;

    sched_scoreboard sb;
    int              idle_pct = 0;

    priority_preemptive_tick_scheduler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_stb   (o_res_stb),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_res_stb === 1'b1) sb.check_result(o_res);
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_in load_item(int slot, int burst, int arr, int prio);
        t_in it;
        it              = '0;
        it.opcode       = OP_LOAD;
        it.slot         = slot[SLOT_W-1:0];
        it.burst_length = burst[WORK_W-1:0];
        it.arrival      = arr[TICK_W-1:0];
        it.prio_level   = prio[PRIO_W-1:0];
        return it;
    endfunction

    function automatic t_in tick_item();
        t_in it;
        it        = '0;
        it.opcode = OP_TICK;
        return it;
    endfunction

    // Mostly loads that arrive close to the current time with small bursts
    // and crowded priorities, so entries keep finishing and ties come up.
    function automatic t_in random_item(logic [TIME_W-1:0] now);
        t_in it;
        int  pick;
        int  arr;
        it.opcode       = ($urandom_range(99) < 48) ? OP_TICK : OP_LOAD;
        it.slot         = SLOT_W'(($urandom_range(99) < 60) ? $urandom_range(15)
                                                    : $urandom_range(DEF_MAX_SLOTS - 1));
        it.prio_level   = PRIO_W'(($urandom_range(99) < 70) ? $urandom_range(7)
                                                            : $urandom_range(1023));
        it.burst_length = WORK_W'($urandom_range(65535));
        it.arrival      = TICK_W'($urandom_range(65535));
        if (it.opcode == OP_TICK) return it;  // unused fields stay random

        pick = $urandom_range(99);
        if (pick < 3) begin
            it.burst_length = '0;
        end else if (pick < 6) begin
            // long job kept at the back so it does not starve the rest
            it.burst_length = WORK_W'($urandom_range(65535, 1));
            it.prio_level   = PRIO_W'($urandom_range(1023, 900));
        end else if (pick < 70) begin
            it.burst_length = WORK_W'(1);
        end else if (pick < 94) begin
            it.burst_length = WORK_W'($urandom_range(4, 2));
        end else begin
            it.burst_length = WORK_W'($urandom_range(20, 5));
        end

        pick = $urandom_range(99);
        if (pick < 8) begin
            it.arrival = TICK_W'($urandom_range(65535));
        end else if (pick < 16) begin
            it.arrival = '0;
        end else begin
            arr = int'(now) + int'($urandom_range(11)) - 3;
            if (arr < 0) arr = 0;
            if (arr > 65535) arr = 65535;
            it.arrival = arr[TICK_W-1:0];
        end
        return it;
    endfunction

    task automatic send_item(input t_in item);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(140, 1) : $urandom_range(4, 1))
                @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.schedule_item(item);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.proc_count = value;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [COUNT_W-1:0] phase_count [3];
        int                 phase_idle  [3];
        phase_count = '{8'd0, 8'd128, 8'd255};
        phase_idle  = '{36, 83, 0};
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_count(8'd2);
        send_item(tick_item());                     // empty table: idle tick
        send_item(load_item(127, 2, 0, 5));
        send_item(load_item(3, 1, 0, 5));           // same priority, lower slot wins
        send_item(load_item(64, 0, 0, 0));          // zero burst never runs
        send_item(load_item(10, 65535, 65535, 1023));
        send_item(load_item(20, 3, 0, 998));
        send_item(tick_item());
        send_item(tick_item());
        send_item(load_item(127, 2, 1, 0));         // overwrite a half-run entry
        send_item(tick_item());
        send_item(tick_item());                     // second finish: all_done
        send_item(load_item(5, 1, 7, 0));           // arrives later, then preempts
        send_item(tick_item());
        send_item(tick_item());
        send_item(tick_item());
        send_item(tick_item());
        send_item(tick_item());
        send_item(load_item(0, 65535, 0, 1023));
        send_item(tick_item());
        drain_results();

        for (int p = 0; p < 3; p++) begin
            write_count(phase_count[p]);
            idle_pct = phase_idle[p];
            repeat (PHASE_ITEMS) send_item(random_item(sb.now));
            drain_results();
        end

        repeat (DEF_MAX_SLOTS + 8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
